### hdl/bus_frame_receiver_assert.svh
// Assertion macros for the bus frame receiver.
// Expects clk and rst in the scope of each use.
`ifndef BUS_FRAME_RECEIVER_ASSERT_SVH
`define BUS_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTH
`define BFR_CHECK_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bus_frame_receiver: assertion failed");
`define BFR_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bus_frame_receiver: assertion failed");
`else
`define BFR_CHECK_IMP(name, ante, cons)
`define BFR_CHECK_NEXT(name, ante, cons)
`endif

`endif

### hdl/bfr_pkg.sv
// Shared types and constants of the bus frame receiver.
// No dependencies.
package bfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned HDR_CNT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [BYTE_W-1:0]  START_BYTE      = 8'hA5;
  localparam logic [ADDR_W-1:0]  BROADCAST_ADDR  = 48'hFFFF_FFFF_FFFF;
  localparam logic [INDEX_W-1:0] MAX_PAYLOAD_RST = 10'd1006;

  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  type_code;
    logic [ADDR_W-1:0]  source_address;
    logic [ID_W-1:0]    message_id;
    logic [LEN_W-1:0]   payload_length;
    logic               to_all;
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  data_byte;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } beat_t;

endpackage

### hdl/bfr_in_if.sv
// Receive byte channel: valid/ready transaction carrying one bus byte.
// Depends on bfr_pkg.
interface bfr_in_if;
  import bfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/bfr_out_if.sv
// Result channel: valid/ready transaction carrying one frame result.
// Depends on bfr_pkg.
interface bfr_out_if;
  import bfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  type_code;
  logic [ADDR_W-1:0]  source_address;
  logic [ID_W-1:0]    message_id;
  logic [LEN_W-1:0]   payload_length;
  logic               to_all;
  logic [INDEX_W-1:0] byte_index;
  logic [BYTE_W-1:0]  data_byte;
  logic               last;

  modport source (
    output valid, output kind, output type_code, output source_address,
    output message_id, output payload_length, output to_all,
    output byte_index, output data_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input type_code, input source_address,
    input message_id, input payload_length, input to_all,
    input byte_index, input data_byte, input last, output ready
  );
endinterface

### hdl/bfr_parser.sv
// Frame parser: hunt, header collection and payload tracking, plus config registers.
// Depends on bfr_pkg and bus_frame_receiver_assert.svh.
`include "bus_frame_receiver_assert.svh"

module bfr_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  logic [bfr_pkg::BYTE_W-1:0]         rx_byte,
  input  logic                               wr_en,
  input  logic [bfr_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [bfr_pkg::ADDR_W-1:0]         wr_data,
  output bfr_pkg::beat_t                     beat
);
  import bfr_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [HDR_CNT_W-1:0] POS_TYPE   = 5'd0;
  localparam logic [HDR_CNT_W-1:0] POS_LEN_LO = 5'd1;
  localparam logic [HDR_CNT_W-1:0] POS_LEN_HI = 5'd2;
  localparam logic [HDR_CNT_W-1:0] POS_SRC    = 5'd3;
  localparam logic [HDR_CNT_W-1:0] POS_DST    = 5'd9;
  localparam logic [HDR_CNT_W-1:0] POS_ID_LO  = 5'd15;
  localparam logic [HDR_CNT_W-1:0] POS_LAST   = 5'd16;

  logic [ADDR_W-1:0]    own_address;
  logic [INDEX_W-1:0]   max_payload;

  logic [1:0]           phase, phase_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [BYTE_W-1:0]    frame_type, frame_type_next;
  logic [LEN_W-1:0]     declared_length, declared_length_next;
  logic [ADDR_W-1:0]    sender_address, sender_address_next;
  logic [ADDR_W-1:0]    target_address, target_address_next;
  logic [ID_W-1:0]      frame_id, frame_id_next;
  logic [INDEX_W-1:0]   payload_count, payload_count_next;
  logic                 frame_accepted, frame_accepted_next;

  logic [2:0]           src_sel, dst_sel;
  logic                 hit;
  logic                 pay_last;

  assign src_sel  = 3'(header_count - POS_SRC);
  assign dst_sel  = 3'(header_count - POS_DST);
  assign hit      = (target_address_next == own_address) ||
                    (target_address_next == BROADCAST_ADDR);
  assign pay_last = LEN_W'({1'b0, payload_count} + 11'd1) >= declared_length;

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    frame_type_next      = frame_type;
    declared_length_next = declared_length;
    sender_address_next  = sender_address;
    target_address_next  = target_address;
    frame_id_next        = frame_id;
    payload_count_next   = payload_count;
    frame_accepted_next  = frame_accepted;
    beat                 = '0;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == START_BYTE) begin
          phase_next           = PH_HEADER;
          header_count_next    = '0;
          frame_type_next      = '0;
          declared_length_next = '0;
          sender_address_next  = '0;
          target_address_next  = '0;
          frame_id_next        = '0;
          payload_count_next   = '0;
          frame_accepted_next  = 1'b0;
        end
      end
      PH_HEADER: begin
        if (header_count == POS_TYPE) begin
          frame_type_next = rx_byte;
        end else if (header_count == POS_LEN_LO) begin
          declared_length_next[7:0] = rx_byte;
        end else if (header_count == POS_LEN_HI) begin
          declared_length_next[15:8] = rx_byte;
        end else if (header_count < POS_DST) begin
          sender_address_next[{src_sel, 3'b000} +: BYTE_W] = rx_byte;
        end else if (header_count < POS_ID_LO) begin
          target_address_next[{dst_sel, 3'b000} +: BYTE_W] = rx_byte;
        end else if (header_count == POS_ID_LO) begin
          frame_id_next[7:0] = rx_byte;
        end else begin
          frame_id_next[15:8] = rx_byte;
        end

        if (header_count == POS_LAST) begin
          header_count_next  = '0;
          payload_count_next = '0;
          if (declared_length_next > LEN_W'(max_payload)) begin
            phase_next          = PH_HUNT;
            frame_accepted_next = 1'b0;
            beat.valid          = 1'b1;
            beat.data.kind      = KIND_ERROR;
            beat.data.last      = 1'b1;
          end else begin
            frame_accepted_next = hit;
            phase_next = (declared_length_next == '0) ? PH_HUNT : PH_PAYLOAD;
            beat.valid          = hit;
            beat.data.kind      = KIND_HEADER;
            beat.data.last      = (declared_length_next == '0);
          end
        end else begin
          header_count_next = header_count + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        if (pay_last) begin
          phase_next         = PH_HUNT;
          payload_count_next = '0;
        end else begin
          payload_count_next = payload_count + 10'd1;
        end
        beat.valid           = frame_accepted;
        beat.data.kind       = KIND_PAYLOAD;
        beat.data.byte_index = payload_count;
        beat.data.data_byte  = rx_byte;
        beat.data.last       = pay_last;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    beat.data.type_code      = frame_type_next;
    beat.data.source_address = sender_address_next;
    beat.data.message_id     = frame_id_next;
    beat.data.payload_length = declared_length_next;
    beat.data.to_all         = (target_address_next == BROADCAST_ADDR);
    beat.valid               = beat.valid && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      header_count    <= '0;
      frame_type      <= '0;
      declared_length <= '0;
      sender_address  <= '0;
      target_address  <= '0;
      frame_id        <= '0;
      payload_count   <= '0;
      frame_accepted  <= 1'b0;
      own_address     <= '0;
      max_payload     <= MAX_PAYLOAD_RST;
    end else begin
      if (take) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        frame_type      <= frame_type_next;
        declared_length <= declared_length_next;
        sender_address  <= sender_address_next;
        target_address  <= target_address_next;
        frame_id        <= frame_id_next;
        payload_count   <= payload_count_next;
        frame_accepted  <= frame_accepted_next;
      end
      if (wr_en) begin
        unique case (wr_index)
          REG_OWN_ADDRESS: own_address <= wr_data;
          REG_MAX_PAYLOAD: max_payload <= wr_data[INDEX_W-1:0];
        endcase
      end
    end
  end

  `BFR_CHECK_IMP(a_hdr_count_idle, phase != PH_HEADER, header_count == '0)
  `BFR_CHECK_IMP(a_pay_count_idle, phase != PH_PAYLOAD, payload_count == '0)
  `BFR_CHECK_IMP(a_payload_only_accepted,
                 beat.valid && beat.data.kind == KIND_PAYLOAD,
                 phase == PH_PAYLOAD && frame_accepted)

endmodule

### hdl/bfr_out_stage.sv
// Result register with skid stage toward the result channel.
// Depends on bfr_pkg, bfr_out_if and bus_frame_receiver_assert.svh.
`include "bus_frame_receiver_assert.svh"

module bfr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  bfr_pkg::beat_t    push,
  output logic              in_ready,
  bfr_out_if.source         result
);
  import bfr_pkg::*;

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    advance;

  assign advance  = !out_valid || result.ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid  <= skid_valid || push.valid;
        skid_valid <= 1'b0;
      end else if (push.valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= skid_valid ? skid_data : push.data;
    end
    if (!advance && push.valid) begin
      skid_data <= push.data;
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_data.kind;
  assign result.type_code      = out_data.type_code;
  assign result.source_address = out_data.source_address;
  assign result.message_id     = out_data.message_id;
  assign result.payload_length = out_data.payload_length;
  assign result.to_all         = out_data.to_all;
  assign result.byte_index     = out_data.byte_index;
  assign result.data_byte      = out_data.data_byte;
  assign result.last           = out_data.last;

  `BFR_CHECK_IMP(a_skid_behind_out, skid_valid, out_valid)
  `BFR_CHECK_NEXT(a_stall_fills_skid, push.valid && out_valid && !result.ready, skid_valid)
  `BFR_CHECK_NEXT(a_drain_empties,
                  out_valid && result.ready && !skid_valid && !push.valid,
                  !out_valid)

endmodule

### hdl/bus_frame_receiver.sv
// Bus frame receiver top level: parser plus result register with skid stage.
// Depends on bfr_pkg, bfr_in_if, bfr_out_if, bfr_parser and bfr_out_stage.
//
//   channel   direction  transaction
//   rx        in         one received bus byte (rx_byte)
//   result    out        one header, payload or error result
//   wr_*      in         config write, no handshake (index 0 own_address, 1 max_payload)
//
// One byte per cycle while rx.ready is high; each byte updates the parser state in the cycle it is taken.
// A result is registered in the output register, or first in the skid stage while the output is stalled.
// rx.ready drops only while the skid stage holds a result behind a stalled output.
// Synchronous reset returns to hunting with own_address 0 and max_payload 1006.
module bus_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  bfr_in_if.sink                         rx,
  bfr_out_if.source                      result,
  input  logic                           wr_en,
  input  logic [bfr_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bfr_pkg::ADDR_W-1:0]     wr_data
);
  import bfr_pkg::*;

  logic  take;
  logic  in_ready;
  beat_t beat;

  assign rx.ready = in_ready;
  assign take     = rx.valid && in_ready;

  bfr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx.rx_byte),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .beat     (beat)
  );

  bfr_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .push     (beat),
    .in_ready (in_ready),
    .result   (result)
  );

endmodule
